### rtl/spq_pkg.sv
package spq_pkg;

  // Fixed field widths
  localparam int PRIO_W = 16;
  localparam int DATA_W = 32;
  localparam int CAP_W  = 5;
  localparam int ADDR_W = 3;

  // Register map
  localparam logic [ADDR_W-1:0] ADDR_CAPACITY = 3'd0;
  localparam logic [CAP_W-1:0]  CAPACITY_RESET = 5'd16;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POLL   = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Input item
  typedef struct packed {
    op_t                      operation;
    logic signed [PRIO_W-1:0] new_priority;
    logic [DATA_W-1:0]        new_payload;
  } req_t;

  // Result item
  typedef struct packed {
    status_t                  status;
    logic [DATA_W-1:0]        out_payload;
    logic signed [PRIO_W-1:0] out_priority;
    logic [CAP_W-1:0]         entry_count;
    logic                     is_empty;
  } rsp_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic                     shift_in;
    logic                     shift_out;
    logic signed [PRIO_W-1:0] new_priority;
  } cell_ctrl_t;

endpackage

### rtl/spq_cell.sv
module spq_cell #(
  parameter int PAY_WIDTH = 32
) (
  input  logic                              clk,
  input  spq_pkg::cell_ctrl_t               ctrl,
  input  logic [PAY_WIDTH-1:0]              new_payload,
  input  logic                              occupied,
  input  logic                              left_ge,
  input  logic signed [spq_pkg::PRIO_W-1:0] left_priority,
  input  logic [PAY_WIDTH-1:0]              left_payload,
  input  logic signed [spq_pkg::PRIO_W-1:0] right_priority,
  input  logic [PAY_WIDTH-1:0]              right_payload,
  output logic                              ge,
  output logic signed [spq_pkg::PRIO_W-1:0] slot_priority,
  output logic [PAY_WIDTH-1:0]              slot_payload
);

  // An empty slot counts as larger than any priority
  assign ge = !occupied || (slot_priority >= ctrl.new_priority);

  // Insert: first ge cell takes the new item, those after it take from the left.
  // Poll: every cell takes from the right.
  always_ff @(posedge clk) begin
    if (ctrl.shift_in) begin
      if (ge && !left_ge) begin
        slot_priority <= ctrl.new_priority;
        slot_payload  <= new_payload;
      end else if (ge) begin
        slot_priority <= left_priority;
        slot_payload  <= left_payload;
      end
    end else if (ctrl.shift_out) begin
      slot_priority <= right_priority;
      slot_payload  <= right_payload;
    end
  end

endmodule

### rtl/sorted_priority_queue_core.sv
// Channel   Direction  Handshake              Payload
// req       in         req_valid / req_ready  spq_pkg::req_t (insert or poll)
// rsp       out        rsp_valid / rsp_ready  spq_pkg::rsp_t (status, entry, count)
// apb       in         psel/penable/pready    queue_capacity at byte address 0
//
// One item per cycle while rsp_ready stays high; each result appears in the cycle
// after its item is taken. A row of DEPTH cells compares against the new priority
// in parallel and shifts by one place per item, so every insert or poll is done at
// once. Reset clears the count and sets the capacity to 16; slot contents stay
// unknown. A result waits in the output register while rsp_ready is low; req_ready
// is high whenever that register is empty or is being emptied in the same cycle.
module sorted_priority_queue_core #(
  parameter int DEPTH         = 16,
  parameter int PAYLOAD_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  spq_pkg::req_t                req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output spq_pkg::rsp_t                rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spq_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam int CW = $clog2(DEPTH + 1);

  logic [spq_pkg::CAP_W-1:0] capacity;
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  spq_pkg::rsp_t             rsp_next;
  spq_pkg::cell_ctrl_t       ctrl;

  logic                              accept;
  logic                              full;
  logic                              do_insert;
  logic                              do_poll;
  logic [63:0]                       pay_in_wide;
  logic [63:0]                       pay_out_wide;
  logic [PAYLOAD_WIDTH-1:0]          new_pay;

  logic                              ge     [DEPTH];
  logic                              occ    [DEPTH];
  logic signed [spq_pkg::PRIO_W-1:0] prio   [DEPTH];
  logic [PAYLOAD_WIDTH-1:0]          pay    [DEPTH];

  // Configuration port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= spq_pkg::CAPACITY_RESET;
    end else if (psel && penable && pwrite && paddr == spq_pkg::ADDR_CAPACITY) begin
      capacity <= pwdata[spq_pkg::CAP_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == spq_pkg::ADDR_CAPACITY) begin
      prdata = 32'(capacity);
    end
  end

  // Item decode
  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = (32'(count) >= 32'(capacity)) || (32'(count) >= DEPTH);
  assign do_insert = accept && req.operation == spq_pkg::OP_INSERT && !full;
  assign do_poll   = accept && req.operation == spq_pkg::OP_POLL && count != '0;

  assign pay_in_wide  = 64'(req.new_payload);
  assign new_pay      = pay_in_wide[PAYLOAD_WIDTH-1:0];
  assign pay_out_wide = 64'(pay[0]);

  assign ctrl.shift_in     = do_insert;
  assign ctrl.shift_out    = do_poll;
  assign ctrl.new_priority = req.new_priority;

  // Cell row, front at index 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                              l_ge;
    logic signed [spq_pkg::PRIO_W-1:0] l_prio;
    logic [PAYLOAD_WIDTH-1:0]          l_pay;
    logic signed [spq_pkg::PRIO_W-1:0] r_prio;
    logic [PAYLOAD_WIDTH-1:0]          r_pay;

    assign occ[i] = CW'(i) < count;

    if (i == 0) begin : g_first
      assign l_ge   = 1'b0;
      assign l_prio = req.new_priority;
      assign l_pay  = new_pay;
    end else begin : g_mid
      assign l_ge   = ge[i-1];
      assign l_prio = prio[i-1];
      assign l_pay  = pay[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_prio = prio[i];
      assign r_pay  = pay[i];
    end else begin : g_inner
      assign r_prio = prio[i+1];
      assign r_pay  = pay[i+1];
    end

    spq_cell #(
      .PAY_WIDTH(PAYLOAD_WIDTH)
    ) u_cell (
      .clk           (clk),
      .ctrl          (ctrl),
      .new_payload   (new_pay),
      .occupied      (occ[i]),
      .left_ge       (l_ge),
      .left_priority (l_prio),
      .left_payload  (l_pay),
      .right_priority(r_prio),
      .right_payload (r_pay),
      .ge            (ge[i]),
      .slot_priority (prio[i]),
      .slot_payload  (pay[i])
    );
  end

  // Count and result
  always_comb begin
    count_next = count;
    if (do_insert) begin
      count_next = count + CW'(1);
    end else if (do_poll) begin
      count_next = count - CW'(1);
    end

    rsp_next.status       = spq_pkg::ST_DONE;
    rsp_next.out_payload  = '0;
    rsp_next.out_priority = '0;
    if (req.operation == spq_pkg::OP_INSERT) begin
      if (full) begin
        rsp_next.status = spq_pkg::ST_FULL;
      end
    end else if (count == '0) begin
      rsp_next.status = spq_pkg::ST_EMPTY;
    end else begin
      rsp_next.out_payload  = pay_out_wide[spq_pkg::DATA_W-1:0];
      rsp_next.out_priority = prio[0];
    end
    rsp_next.entry_count = spq_pkg::CAP_W'(count_next);
    rsp_next.is_empty    = count_next == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= rsp_next;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= DEPTH)
    else $error("entry count above depth");

  a_rsp_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> 32'(rsp.entry_count) == 32'(count))
    else $error("result count differs from held count");

  a_poll_dec: assert property (@(posedge clk) disable iff (rst)
    do_poll |=> count == $past(count) - CW'(1))
    else $error("poll did not remove an entry");

  a_refused_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && !do_insert && !do_poll) |=> $stable(count))
    else $error("refused item changed the count");

  a_front_sorted: assert property (@(posedge clk) disable iff (rst)
    (occ[0] && occ[1 % DEPTH] && DEPTH > 1) |-> prio[0] <= prio[1 % DEPTH])
    else $error("front entries out of order");

endmodule

### test/sorted_priority_queue_core_tb.sv
`timescale 1ns / 1ps

module sorted_priority_queue_core_tb;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 112;

  typedef enum {ROW_ITEM, ROW_CAPACITY} row_kind_t;

  // One line of the directed table; data carries the capacity for ROW_CAPACITY
  typedef struct {
    row_kind_t          kind;
    spq_pkg::op_t       op;
    logic signed [15:0] prio;
    logic [31:0]        data;
    bit                 fixed;
    spq_pkg::rsp_t      want;
  } dir_row_t;

  logic                        clk;
  logic                        rst = 1'b1;
  logic                        req_valid = 1'b0;
  logic                        req_ready;
  spq_pkg::req_t               req = '0;
  logic                        rsp_valid;
  logic                        rsp_ready = 1'b0;
  spq_pkg::rsp_t               rsp;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [spq_pkg::ADDR_W-1:0]  paddr = '0;
  logic [31:0]                 pwdata = '0;
  logic [31:0]                 prdata;
  logic                        pready;

  // Hard-coded expectation travelling alongside the item being offered
  logic                        use_fixed = 1'b0;
  spq_pkg::rsp_t               fixed_rsp = '0;

  // Mirror of the queue contents and the capacity register
  logic signed [15:0]  mirror_prio [DEPTH];
  logic [31:0]         mirror_data [DEPTH];
  int                  mirror_count;
  int                  mirror_capacity;

  spq_pkg::rsp_t       due_results [$];
  int                  mismatches = 0;
  int                  send_idle_pct = 0;
  int                  stall_pct = 0;
  int                  cycles = 0;

  sorted_priority_queue_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one insert or poll to the mirror and return the result it gives
  function automatic spq_pkg::rsp_t apply_queue_op(input spq_pkg::req_t item);
    spq_pkg::rsp_t      r;
    int                 limit;
    int                 pos;
    logic signed [15:0] np;
    r = '0;
    r.status = spq_pkg::ST_DONE;
    np = item.new_priority;
    limit = (mirror_capacity > DEPTH) ? DEPTH : mirror_capacity;
    if (item.operation == spq_pkg::OP_INSERT) begin
      if (mirror_count >= limit) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        // goes ahead of the first entry not below it, so ties serve newest first
        pos = mirror_count;
        for (int i = mirror_count - 1; i >= 0; i--)
          if (mirror_prio[i] >= np) pos = i;
        for (int i = mirror_count; i > pos; i--) begin
          mirror_prio[i] = mirror_prio[i-1];
          mirror_data[i] = mirror_data[i-1];
        end
        mirror_prio[pos] = np;
        mirror_data[pos] = item.new_payload;
        mirror_count++;
      end
    end else if (mirror_count == 0) begin
      r.status = spq_pkg::ST_EMPTY;
    end else begin
      r.out_payload = mirror_data[0];
      r.out_priority = mirror_prio[0];
      for (int i = 1; i < mirror_count; i++) begin
        mirror_prio[i-1] = mirror_prio[i];
        mirror_data[i-1] = mirror_data[i];
      end
      mirror_count--;
    end
    r.entry_count = 5'(mirror_count);
    r.is_empty = (mirror_count == 0);
    return r;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Result checking and expectation capture
  always @(posedge clk) begin : monitor
    spq_pkg::rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing, got %h", $time, rsp);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          report_field("status", 32'(want.status), 32'(rsp.status));
          report_field("out_payload", want.out_payload, rsp.out_payload);
          report_field("out_priority", 32'(want.out_priority), 32'(rsp.out_priority));
          report_field("entry_count", 32'(want.entry_count), 32'(rsp.entry_count));
          report_field("is_empty", 32'(want.is_empty), 32'(rsp.is_empty));
        end
      end
      if (req_valid && req_ready) begin
        want = apply_queue_op(req);
        due_results.push_back(use_fixed ? fixed_rsp : want);
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    rsp_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** sorted_priority_queue_core: FAILED **");
      $finish;
    end
  end

  task automatic send_item(input spq_pkg::req_t item, input bit fixed,
                           input spq_pkg::rsp_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    use_fixed <= fixed;
    fixed_rsp <= want;
    do @(posedge clk); while (!req_ready);
  endtask

  // Hold the sender off until every outstanding result has come back
  task automatic drain;
    req_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_capacity(input int value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= spq_pkg::ADDR_CAPACITY;
    pwdata <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    mirror_capacity = value & 32'h1f;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic logic signed [15:0] pick_priority();
    logic signed [15:0] p;
    case ($urandom_range(3))
      0: p = 16'(int'($urandom_range(8)) - 4);
      1: begin
        case ($urandom_range(3))
          0: p = 16'sh8000;
          1: p = 16'sh7fff;
          2: p = 16'shffff;
          default: p = 16'sh0000;
        endcase
      end
      default: p = 16'($urandom);
    endcase
    return p;
  endfunction

  initial begin : stimulus
    dir_row_t      dir_rows [$];
    spq_pkg::req_t item;
    int       phase_send [PHASES] = '{0, 88, 0, 22, 0, 88, 0, 22};
    int       phase_stall [PHASES] = '{0, 0, 88, 22, 0, 0, 88, 22};
    int       phase_cap [PHASES] = '{16, 31, 4, 16, 1, 0, 17, 2};
    int       phase_ins [PHASES] = '{75, 60, 45, 70, 50, 50, 65, 40};

    mirror_count = 0;
    mirror_capacity = spq_pkg::CAPACITY_RESET;

    // empty poll, extremes, tie order, largest at the end
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_POLL, 16'sh0, 32'h0, 1'b1,
                         '{spq_pkg::ST_EMPTY, 32'h0, 16'sh0, 5'd0, 1'b1}});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_INSERT, 16'sh0, 32'hffffffff, 1'b1,
                         '{spq_pkg::ST_DONE, 32'h0, 16'sh0, 5'd1, 1'b0}});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_INSERT, 16'sh8000, 32'h0, 1'b1,
                         '{spq_pkg::ST_DONE, 32'h0, 16'sh0, 5'd2, 1'b0}});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_INSERT, 16'sh7fff, 32'ha5a5a5a5, 1'b1,
                         '{spq_pkg::ST_DONE, 32'h0, 16'sh0, 5'd3, 1'b0}});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_INSERT, 16'sh0, 32'h12345678, 1'b1,
                         '{spq_pkg::ST_DONE, 32'h0, 16'sh0, 5'd4, 1'b0}});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_POLL, 16'sh0, 32'h0, 1'b1,
                         '{spq_pkg::ST_DONE, 32'h0, 16'sh8000, 5'd3, 1'b0}});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_POLL, 16'sh0, 32'h0, 1'b1,
                         '{spq_pkg::ST_DONE, 32'h12345678, 16'sh0, 5'd2, 1'b0}});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_POLL, 16'sh0, 32'h0, 1'b1,
                         '{spq_pkg::ST_DONE, 32'hffffffff, 16'sh0, 5'd1, 1'b0}});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_POLL, 16'sh0, 32'h0, 1'b1,
                         '{spq_pkg::ST_DONE, 32'ha5a5a5a5, 16'sh7fff, 5'd0, 1'b1}});
    // capacity of one, then zero with an entry still held
    dir_rows.push_back('{ROW_CAPACITY, spq_pkg::OP_INSERT, 16'sh0, 32'd1, 1'b0, '0});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_INSERT, 16'shffff, 32'h5a5a5a5a, 1'b1,
                         '{spq_pkg::ST_DONE, 32'h0, 16'sh0, 5'd1, 1'b0}});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_INSERT, 16'shfffe, 32'h1, 1'b1,
                         '{spq_pkg::ST_FULL, 32'h0, 16'sh0, 5'd1, 1'b0}});
    dir_rows.push_back('{ROW_CAPACITY, spq_pkg::OP_INSERT, 16'sh0, 32'd0, 1'b0, '0});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_INSERT, 16'sd100, 32'h2, 1'b1,
                         '{spq_pkg::ST_FULL, 32'h0, 16'sh0, 5'd1, 1'b0}});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_POLL, 16'sh0, 32'h0, 1'b1,
                         '{spq_pkg::ST_DONE, 32'h5a5a5a5a, 16'shffff, 5'd0, 1'b1}});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_INSERT, 16'sd100, 32'h2, 1'b1,
                         '{spq_pkg::ST_FULL, 32'h0, 16'sh0, 5'd0, 1'b1}});
    // capacity above the depth, with three inserts and three polls
    dir_rows.push_back('{ROW_CAPACITY, spq_pkg::OP_INSERT, 16'sh0, 32'd31, 1'b0, '0});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_INSERT, 16'sd300, 32'hdeadbeef, 1'b0, '0});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_INSERT, -16'sd300, 32'h0f0f0f0f, 1'b0, '0});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_INSERT, 16'sd300, 32'h3, 1'b0, '0});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_POLL, 16'sh0, 32'h0, 1'b0, '0});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_POLL, 16'sh0, 32'h0, 1'b0, '0});
    dir_rows.push_back('{ROW_ITEM, spq_pkg::OP_POLL, 16'sh0, 32'h0, 1'b0, '0});
    dir_rows.push_back('{ROW_CAPACITY, spq_pkg::OP_INSERT, 16'sh0, 32'd16, 1'b0, '0});

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CAPACITY) begin
        write_capacity(int'(dir_rows[i].data));
      end else begin
        item.operation = dir_rows[i].op;
        item.new_priority = dir_rows[i].prio;
        item.new_payload = dir_rows[i].data;
        send_item(item, dir_rows[i].fixed, dir_rows[i].want);
      end
    end

    // random phases, each with its own capacity, idling, stalling and insert mix
    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(phase_cap[ph]);
      send_idle_pct = phase_send[ph];
      stall_pct = phase_stall[ph];
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n == PHASE_ITEMS / 2) drain();
        item.operation = ($urandom_range(99) < phase_ins[ph]) ?
                         spq_pkg::OP_INSERT : spq_pkg::OP_POLL;
        item.new_priority = pick_priority();
        item.new_payload = $urandom;
        send_item(item, 1'b0, '0);
      end
    end

    send_idle_pct = 0;
    stall_pct = 0;
    req_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (10) @(posedge clk);

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("** sorted_priority_queue_core: PASSED **");
    end else begin
      $display("** sorted_priority_queue_core: FAILED **");
    end
    $finish;
  end

endmodule

### sim.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_core.sv
test/sorted_priority_queue_core_tb.sv
